### rtl/vpc_pkg.sv
// Package for the vibrator pulse controller: opcode, status and register codes,
// reset values and default sizes shared by the core and its checker.
// No dependencies.
package vpc_pkg;

  // Default width of the pulse tick counter
  localparam int unsigned TickWidthDefault = 16;

  // Configuration field widths and reset values
  localparam int unsigned VoltWidth     = 3;
  localparam int unsigned MaxOnWidth    = 16;
  localparam logic [MaxOnWidth-1:0] MaxOnReset = 16'd5000;

  // APB port geometry: 32-bit data, three registers at byte addresses 0, 4, 8
  localparam int unsigned ApbAddrWidth  = 4;
  localparam int unsigned ApbDataWidth  = 32;

  typedef enum logic [1:0] {
    RegDriveVoltage = 2'd0,
    RegIdleVoltage  = 2'd1,
    RegMaxOnTicks   = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    OpPlay     = 3'd0,
    OpTick     = 3'd1,
    OpSuspend  = 3'd2,
    OpResume   = 3'd3,
    OpClose    = 3'd4,
    OpTeardown = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusShutDown = 2'd1,
    StatusBusy     = 2'd2
  } status_e;

endpackage

### rtl/vibrator_pulse_controller_core.sv
// Vibrator pulse controller core: input register, one-pass event logic and
// result register, plus the APB configuration registers.
// Depends on vpc_pkg.

// Usage
// -----
// Input channel (in_valid_i / in_stall_o) carries one event beat: opcode,
// strong and weak magnitude, and the access error flag of the output stage.
// Output channel (out_valid_o / out_stall_i) returns exactly one result beat
// per input beat: request status, motor power, applied voltage code, fault
// and pulse flags, all as they stand after the event.
// An accepted beat is captured in the input register; the event logic then
// runs on it, updates the controller state and loads the result register
// once the result register is free or being drained.
// Throughput is one beat per cycle unless the receiver stalls; the input
// register hands over to the result register whenever it is free or drained.
// When the receiver stalls, the result register holds its beat, the input
// register fills up behind it, and in_stall_o rises only when both are full.
// Reset (rst_ni low) clears every flag and the tick counter, sets the applied
// voltage code to zero, loads max_on_ticks with 5000 and drops both valids.
// Drive voltage, idle voltage and max on ticks registers are written over
// APB at 0, 4, 8 by the user, only while no beat is in flight; not enforced.
module vibrator_pulse_controller_core #(
  parameter int unsigned TICK_WIDTH = vpc_pkg::TickWidthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vpc_pkg::ApbAddrWidth-1:0]  paddr,
  input  logic [vpc_pkg::ApbDataWidth-1:0]  pwdata,
  output logic [vpc_pkg::ApbDataWidth-1:0]  prdata,
  output logic                              pready,

  // Event input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        opcode_i,
  input  logic [15:0]                       strong_magnitude_i,
  input  logic [15:0]                       weak_magnitude_i,
  input  logic                              access_error_i,

  // Result output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic                              motor_on_o,
  output logic [vpc_pkg::VoltWidth-1:0]     voltage_out_o,
  output logic                              fault_latched_o,
  output logic                              pulse_busy_o
);

  localparam int unsigned VW   = vpc_pkg::VoltWidth;
  localparam int unsigned MW   = vpc_pkg::MaxOnWidth;
  // Wide enough to compare the register against the counter maximum
  localparam int unsigned LenW = (TICK_WIDTH > MW) ? TICK_WIDTH : MW;
  localparam logic [TICK_WIDTH-1:0] TickMax = {TICK_WIDTH{1'b1}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [VW-1:0] drive_volt_q;
  logic [VW-1:0] idle_volt_q;
  logic [MW-1:0] max_on_q;
  logic          cfg_wr;
  logic [1:0]    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_volt_q <= '0;
      idle_volt_q  <= '0;
      max_on_q     <= vpc_pkg::MaxOnReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        vpc_pkg::RegDriveVoltage: drive_volt_q <= pwdata[VW-1:0];
        vpc_pkg::RegIdleVoltage:  idle_volt_q  <= pwdata[VW-1:0];
        vpc_pkg::RegMaxOnTicks:   max_on_q     <= pwdata[MW-1:0];
        default: ;  // address beyond the register list: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      vpc_pkg::RegDriveVoltage: prdata = vpc_pkg::ApbDataWidth'(drive_volt_q);
      vpc_pkg::RegIdleVoltage:  prdata = vpc_pkg::ApbDataWidth'(idle_volt_q);
      vpc_pkg::RegMaxOnTicks:   prdata = vpc_pkg::ApbDataWidth'(max_on_q);
      default:                  prdata = '0;
    endcase
  end

  // Pulse length, saturated to the counter range
  logic [LenW-1:0]       max_on_ext;
  logic [TICK_WIDTH-1:0] pulse_len;

  assign max_on_ext = LenW'(max_on_q);
  assign pulse_len  = (max_on_ext > LenW'(TickMax)) ? TickMax
                                                    : max_on_ext[TICK_WIDTH-1:0];

  // ---------------------------------------------------------------------------
  // Handshake: input register feeds result register
  // ---------------------------------------------------------------------------
  logic in_vld_q;
  logic out_vld_q;
  logic advance;     // result register can take a beat this cycle
  logic step;        // input register beat is processed this cycle
  logic in_accept;

  assign advance    = ~out_vld_q | ~out_stall_i;
  assign step       = in_vld_q & advance;
  assign in_stall_o = in_vld_q & ~advance;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // Input payload register
  logic [2:0] opcode_q;
  logic       turn_on_q;
  logic       err_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      opcode_q  <= opcode_i;
      turn_on_q <= (strong_magnitude_i != '0) | (weak_magnitude_i != '0);
      err_q     <= access_error_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Controller state
  // ---------------------------------------------------------------------------
  logic                  pulse_q,   pulse_d;
  logic                  req_q,     req_d;
  logic                  susp_q,    susp_d;
  logic                  tdown_q,   tdown_d;
  logic                  fault_q,   fault_d;
  logic                  owned_q,   owned_d;
  logic                  pon_q,     pon_d;
  logic [TICK_WIDTH-1:0] ticks_q,   ticks_d;
  logic [VW-1:0]         volt_q,    volt_d;
  logic [1:0]            status_d;

  logic do_apply;
  logic do_force;
  logic fault_set;
  logic run_ok;
  logic blocked;

  assign blocked = tdown_q | susp_q | fault_q;
  assign run_ok  = pulse_q & req_q & ~susp_q & ~tdown_q & ~fault_q;

  always_comb begin
    pulse_d   = pulse_q;
    req_d     = req_q;
    susp_d    = susp_q;
    tdown_d   = tdown_q;
    fault_d   = fault_q;
    owned_d   = owned_q;
    pon_d     = pon_q;
    ticks_d   = ticks_q;
    volt_d    = volt_q;
    status_d  = vpc_pkg::StatusOk;
    do_apply  = 1'b0;
    do_force  = 1'b0;
    fault_set = 1'b0;

    // Phase one: decode the event
    unique case (opcode_q)
      vpc_pkg::OpPlay: begin
        if (blocked) begin
          status_d = vpc_pkg::StatusShutDown;
        end else if (turn_on_q) begin
          if (pulse_q) begin
            status_d = vpc_pkg::StatusBusy;
          end else begin
            pulse_d  = 1'b1;
            req_d    = 1'b1;
            ticks_d  = pulse_len;
            do_apply = 1'b1;
          end
        end else if (pulse_q) begin
          // zero magnitude ends the running pulse
          req_d    = 1'b0;
          do_apply = 1'b1;
        end
      end
      vpc_pkg::OpTick: begin
        if (run_ok) begin
          if (ticks_q != '0) begin
            ticks_d = ticks_q - TICK_WIDTH'(1);
          end
          if (ticks_d == '0) begin
            req_d    = 1'b0;
            do_apply = 1'b1;
          end
        end
      end
      vpc_pkg::OpSuspend: begin
        susp_d   = 1'b1;
        do_force = 1'b1;
      end
      vpc_pkg::OpResume: begin
        if (!tdown_q && !fault_q) begin
          susp_d = 1'b0;
        end
      end
      vpc_pkg::OpClose: begin
        do_force = 1'b1;
      end
      vpc_pkg::OpTeardown: begin
        if (!tdown_q) begin
          tdown_d  = 1'b1;
          do_force = 1'b1;
        end
      end
      default: ;
    endcase

    // Phase two: drive the output stage on or off
    if (do_apply && pulse_d && req_d && !susp_d && !tdown_d && !fault_d &&
        (ticks_d != '0)) begin
      if (!owned_d) begin
        if (pon_d || err_q) begin
          fault_set = 1'b1;
        end else begin
          pon_d   = 1'b1;
          owned_d = 1'b1;
          volt_d  = drive_volt_q;
        end
      end
    end else if (do_apply || do_force) begin
      req_d = 1'b0;
      if (pon_d && err_q) begin
        fault_set = 1'b1;
      end else begin
        if (pon_d) begin
          pon_d   = 1'b0;
          owned_d = 1'b0;
          volt_d  = idle_volt_q;
        end
        pulse_d = 1'b0;
      end
    end

    // Phase three: a failed switch latches the fault and forces off
    if (fault_set) begin
      fault_d = 1'b1;
      req_d   = 1'b0;
      pulse_d = 1'b0;
      pon_d   = 1'b0;
      owned_d = 1'b0;
      volt_d  = idle_volt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_q <= 1'b0;
      req_q   <= 1'b0;
      susp_q  <= 1'b0;
      tdown_q <= 1'b0;
      fault_q <= 1'b0;
      owned_q <= 1'b0;
      pon_q   <= 1'b0;
      ticks_q <= '0;
      volt_q  <= '0;
    end else if (step) begin
      pulse_q <= pulse_d;
      req_q   <= req_d;
      susp_q  <= susp_d;
      tdown_q <= tdown_d;
      fault_q <= fault_d;
      owned_q <= owned_d;
      pon_q   <= pon_d;
      ticks_q <= ticks_d;
      volt_q  <= volt_d;
    end
  end

  // Result register: load the post-event view of the controller
  logic [1:0]    res_status_q;
  logic          res_motor_q;
  logic [VW-1:0] res_volt_q;
  logic          res_fault_q;
  logic          res_busy_q;

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_status_q <= status_d;
      res_motor_q  <= pon_d;
      res_volt_q   <= volt_d;
      res_fault_q  <= fault_d;
      res_busy_q   <= pulse_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = res_status_q;
  assign motor_on_o      = res_motor_q;
  assign voltage_out_o   = res_volt_q;
  assign fault_latched_o = res_fault_q;
  assign pulse_busy_o    = res_busy_q;

endmodule

### rtl/vpc_checker.sv
// Port-level checker for the vibrator pulse controller core, bound to the core.
// Depends on vpc_pkg and vibrator_pulse_controller_core.
module vpc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [1:0]                    status_o,
  input logic                          motor_on_o,
  input logic [vpc_pkg::VoltWidth-1:0] voltage_out_o,
  input logic                          fault_latched_o,
  input logic                          pulse_busy_o
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(motor_on_o) && $stable(voltage_out_o) &&
      $stable(fault_latched_o) && $stable(pulse_busy_o))
    else $error("stalled result beat changed");

  // A latched fault always leaves the output stage unpowered
  a_fault_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_latched_o |-> !motor_on_o && !pulse_busy_o)
    else $error("output powered with fault latched");

  // Power only flows during a pulse
  a_motor_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motor_on_o |-> pulse_busy_o)
    else $error("motor on without an active pulse");

  // A busy rejection leaves the pulse running
  a_busy_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == vpc_pkg::StatusBusy) |-> pulse_busy_o)
    else $error("busy status without an active pulse");

  // Status never carries the unused code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == vpc_pkg::StatusOk) ||
      (status_o == vpc_pkg::StatusShutDown) || (status_o == vpc_pkg::StatusBusy))
    else $error("undefined status code");

endmodule

bind vibrator_pulse_controller_core vpc_checker u_vpc_checker (.*);

### sim/testbench.sv
// Self-checking testbench for vibrator_pulse_controller_core: event beats and APB
// register writes go in, and every result beat is predicted and compared field by field.
// Depends on vpc_pkg and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes the block treats as no-ops
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;

  localparam int unsigned TickW       = vpc_pkg::TickWidthDefault;
  localparam int unsigned AddrW       = vpc_pkg::ApbAddrWidth;
  localparam int unsigned GapMax      = 13;        // longest idle or stall burst
  localparam int unsigned SettleDelay = 8;         // cycles past the last beat at the end
  localparam int unsigned TickMax     = (1 << TickW) - 1;
  localparam int unsigned RunLimitNs  = 2_000_000;

  // One result beat, laid out in port order so the outputs pack straight in
  typedef struct packed {
    vpc_pkg::status_e              status;
    logic                          motor_on;
    logic [vpc_pkg::VoltWidth-1:0] voltage;
    logic                          fault;
    logic                          busy;
  } outcome_t;

  // Tracks the controller state, predicts one outcome per accepted event beat
  // and checks result beats against the oldest pending outcome.
  class vibe_tracker;
    logic [vpc_pkg::VoltWidth-1:0]  drive_volt;
    logic [vpc_pkg::VoltWidth-1:0]  idle_volt;
    logic [vpc_pkg::MaxOnWidth-1:0] max_on;
    bit                             pulsing;
    bit                             request_on;
    bit                             suspended;
    bit                             torn_down;
    bit                             faulted;
    bit                             owned;
    bit                             maybe_on;
    logic [TickW-1:0]               ticks_left;
    logic [vpc_pkg::VoltWidth-1:0]  applied_volt;
    outcome_t                       pending_outcomes[$];
    int unsigned                    mismatches;

    function new();
      drive_volt   = '0;
      idle_volt    = '0;
      max_on       = vpc_pkg::MaxOnReset;
      pulsing      = 1'b0;
      request_on   = 1'b0;
      suspended    = 1'b0;
      torn_down    = 1'b0;
      faulted      = 1'b0;
      owned        = 1'b0;
      maybe_on     = 1'b0;
      ticks_left   = '0;
      applied_volt = '0;
      mismatches   = 0;
    endfunction

    task report(string what);
      mismatches++;
      $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    function void set_register(vpc_pkg::reg_idx_e idx, logic [31:0] value);
      case (idx)
        vpc_pkg::RegDriveVoltage: drive_volt = value[vpc_pkg::VoltWidth-1:0];
        vpc_pkg::RegIdleVoltage:  idle_volt  = value[vpc_pkg::VoltWidth-1:0];
        vpc_pkg::RegMaxOnTicks:   max_on     = value[vpc_pkg::MaxOnWidth-1:0];
        default: ;
      endcase
    endfunction

    function void trip_fault();
      faulted      = 1'b1;
      request_on   = 1'b0;
      pulsing      = 1'b0;
      maybe_on     = 1'b0;
      owned        = 1'b0;
      applied_volt = idle_volt;
    endfunction

    function bit power_down(bit err);
      if (!maybe_on) return 1'b1;
      if (err) return 1'b0;
      maybe_on     = 1'b0;
      owned        = 1'b0;
      applied_volt = idle_volt;
      return 1'b1;
    endfunction

    function bit power_up(bit err);
      if (owned) return 1'b1;
      if (maybe_on || err) return 1'b0;
      maybe_on     = 1'b1;
      owned        = 1'b1;
      applied_volt = drive_volt;
      return 1'b1;
    endfunction

    function void settle_output(bit err);
      bit want_on;
      want_on = pulsing && request_on && !suspended && !torn_down && !faulted &&
                ticks_left != 0;
      if (!want_on) request_on = 1'b0;
      if (want_on) begin
        if (!power_up(err)) trip_fault();
      end else if (power_down(err)) begin
        pulsing = 1'b0;
      end else begin
        trip_fault();
      end
    endfunction

    function void shut_output(bit err);
      request_on = 1'b0;
      if (power_down(err)) pulsing = 1'b0;
      else trip_fault();
    endfunction

    function void note_event(logic [2:0] op, logic [15:0] strong_mag, logic [15:0] weak_mag,
                             bit err);
      outcome_t res;
      res.status = vpc_pkg::StatusOk;
      case (op)
        vpc_pkg::OpPlay: begin
          if (torn_down || suspended || faulted) begin
            res.status = vpc_pkg::StatusShutDown;
          end else if (strong_mag != 0 || weak_mag != 0) begin
            if (pulsing) begin
              res.status = vpc_pkg::StatusBusy;
            end else begin
              pulsing    = 1'b1;
              request_on = 1'b1;
              ticks_left = (max_on > TickMax) ? TickW'(TickMax) : TickW'(max_on);
              settle_output(err);
            end
          end else if (pulsing) begin
            request_on = 1'b0;
            settle_output(err);
          end
        end
        vpc_pkg::OpTick: begin
          if (pulsing && request_on && !suspended && !torn_down && !faulted) begin
            if (ticks_left != 0) ticks_left--;
            if (ticks_left == 0) begin
              request_on = 1'b0;
              settle_output(err);
            end
          end
        end
        vpc_pkg::OpSuspend: begin
          suspended = 1'b1;
          shut_output(err);
        end
        vpc_pkg::OpResume: begin
          if (!torn_down && !faulted) suspended = 1'b0;
        end
        vpc_pkg::OpClose: shut_output(err);
        vpc_pkg::OpTeardown: begin
          if (!torn_down) begin
            torn_down  = 1'b1;
            request_on = 1'b0;
            shut_output(err);
          end
        end
        default: ;
      endcase
      res.motor_on = maybe_on;
      res.voltage  = applied_volt;
      res.fault    = faulted;
      res.busy     = pulsing;
      pending_outcomes.push_back(res);
    endfunction

    task check_result(outcome_t got);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        report($sformatf("result beat %p with nothing expected", got));
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.motor_on !== want.motor_on)
        report($sformatf("motor_on got %0b want %0b", got.motor_on, want.motor_on));
      if (got.voltage !== want.voltage)
        report($sformatf("voltage_out got %0d want %0d", got.voltage, want.voltage));
      if (got.fault !== want.fault)
        report($sformatf("fault_latched got %0b want %0b", got.fault, want.fault));
      if (got.busy !== want.busy)
        report($sformatf("pulse_busy got %0b want %0b", got.busy, want.busy));
    endtask
  endclass

  // Clock, reset and every block input start at known values
  logic                              clk_i      = 1'b0;
  logic                              rst_n      = 1'b0;
  logic                              psel       = 1'b0;
  logic                              penable    = 1'b0;
  logic                              pwrite     = 1'b0;
  logic [vpc_pkg::ApbAddrWidth-1:0]  paddr      = '0;
  logic [vpc_pkg::ApbDataWidth-1:0]  pwdata     = '0;
  logic [vpc_pkg::ApbDataWidth-1:0]  prdata;
  logic                              pready;
  logic                              in_valid   = 1'b0;
  logic                              in_stall;
  logic [2:0]                        opcode     = '0;
  logic [15:0]                       strong_mag = '0;
  logic [15:0]                       weak_mag   = '0;
  logic                              access_err = 1'b0;
  logic                              out_valid;
  logic                              out_stall  = 1'b0;
  logic [1:0]                        status;
  logic                              motor_on;
  logic [vpc_pkg::VoltWidth-1:0]     voltage_out;
  logic                              fault_latched;
  logic                              pulse_busy;

  // Idling knobs: 0 turns a side's bursts off, otherwise one chance in N each time a burst may start
  int unsigned gap_odds   = 0;
  int unsigned stall_odds = 5;
  bit          calm       = 1'b0;   // end of the run: no idling on either side

  vibe_tracker tracker = new();

  vibrator_pulse_controller_core DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .opcode_i           (opcode),
    .strong_magnitude_i (strong_mag),
    .weak_magnitude_i   (weak_mag),
    .access_error_i     (access_err),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .status_o           (status),
    .motor_on_o         (motor_on),
    .voltage_out_o      (voltage_out),
    .fault_latched_o    (fault_latched),
    .pulse_busy_o       (pulse_busy)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #(RunLimitNs);
    $display("FAIL vibrator_pulse_controller_core");
    $finish;
  end

  // Receiver side: raise stall in random bursts, drop it for good once calm
  initial begin : stall_driver
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (calm) hold = 0;
      if (hold == 0 && !calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
        hold = $urandom_range(1, GapMax);
      out_stall <= (hold != 0);
      if (hold != 0) hold--;
    end
  end

  // Check every result beat taken at a rising edge
  always @(posedge clk_i) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_result({status, motor_on, voltage_out, fault_latched, pulse_busy});
  end

  // Present one event beat at the falling edge and hold it until it is taken;
  // note the prediction at the accepting edge
  task automatic send_beat(logic [2:0] op, logic [15:0] s_mag, logic [15:0] w_mag, bit err);
    @(negedge clk_i);
    in_valid   <= 1'b1;
    opcode     <= op;
    strong_mag <= s_mag;
    weak_mag   <= w_mag;
    access_err <= err;
    do @(posedge clk_i); while (in_stall);
    tracker.note_event(op, s_mag, w_mag, err);
  endtask

  // Drop valid for an idle burst, scrambling opcode, strong magnitude and error flag to show they are ignored
  task automatic idle_sender(int unsigned n);
    @(negedge clk_i);
    in_valid   <= 1'b0;
    opcode     <= 3'($urandom);
    strong_mag <= 16'($urandom);
    access_err <= 1'($urandom);
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Hold off the sender until every pending outcome has arrived
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (tracker.pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_register(vpc_pkg::reg_idx_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(4 * int'(idx));
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_register(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drain, then load all three registers
  task automatic load_settings(logic [31:0] drive, logic [31:0] idle, logic [31:0] max_on);
    wait_drained();
    write_register(vpc_pkg::RegDriveVoltage, drive);
    write_register(vpc_pkg::RegIdleVoltage, idle);
    write_register(vpc_pkg::RegMaxOnTicks, max_on);
  endtask

  // Mostly well-formed traffic: plays, ticks that run pulses out, suspend and resume.
  // Access errors go only where the output is never switched, so the fault stays
  // clear until the closing part. With wild set, anything goes.
  task automatic random_event(bit wild);
    logic [2:0]  op;
    logic [15:0] s_mag;
    logic [15:0] w_mag;
    bit          err;
    int unsigned pick;
    pick  = $urandom_range(0, 99);
    s_mag = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
    w_mag = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
    err   = 1'b0;
    if (wild) begin
      op  = 3'($urandom);
      err = ($urandom_range(0, 3) == 0);
    end else if (pick < 30) begin
      op = vpc_pkg::OpPlay;
    end else if (pick < 38) begin
      op    = vpc_pkg::OpPlay;
      s_mag = '0;
      w_mag = '0;
    end else if (pick < 73) begin
      op = vpc_pkg::OpTick;
    end else if (pick < 79) begin
      op = vpc_pkg::OpSuspend;
    end else if (pick < 89) begin
      op  = vpc_pkg::OpResume;
      err = 1'($urandom);
    end else if (pick < 95) begin
      op = vpc_pkg::OpClose;
    end else begin
      op  = $urandom_range(0, 1) ? OpSpare6 : OpSpare7;
      err = 1'($urandom);
    end
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
      idle_sender($urandom_range(1, GapMax));
    send_beat(op, s_mag, w_mag, err);
  endtask

  initial begin : stimulus
    int unsigned max_on_pick;
    int unsigned fault_path;
    int unsigned run_ticks;

    // Hold reset, then release it at a falling edge
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    // Directed: short pulse of three ticks, distinct drive and idle codes
    load_settings(5, 2, 3);
    send_beat(vpc_pkg::OpPlay, 16'h0000, 16'h0000, 1'b0);      // zero play while idle
    send_beat(OpSpare6, 16'hFFFF, 16'hFFFF, 1'b1);             // unknown opcodes do nothing
    send_beat(OpSpare7, 16'h0000, 16'h0000, 1'b0);
    send_beat(vpc_pkg::OpPlay, 16'hFFFF, 16'h0000, 1'b0);      // start pulse on strong
    send_beat(vpc_pkg::OpPlay, 16'h0000, 16'hFFFF, 1'b1);      // busy, error harmless
    send_beat(vpc_pkg::OpTick, 16'h0000, 16'h0000, 1'b1);      // count down, no switch
    send_beat(vpc_pkg::OpTick, 16'h0000, 16'h0000, 1'b0);
    send_beat(vpc_pkg::OpTick, 16'h0000, 16'h0000, 1'b0);      // expire, output off
    send_beat(vpc_pkg::OpPlay, 16'h0001, 16'h0000, 1'b0);
    send_beat(vpc_pkg::OpPlay, 16'h0000, 16'h0000, 1'b0);      // zero play ends pulse early
    send_beat(vpc_pkg::OpClose, 16'hFFFF, 16'hFFFF, 1'b1);     // close while off, harmless
    send_beat(vpc_pkg::OpPlay, 16'h8000, 16'h8000, 1'b0);
    send_beat(vpc_pkg::OpClose, 16'h0000, 16'h0000, 1'b0);     // force off
    send_beat(vpc_pkg::OpPlay, 16'h0000, 16'h0001, 1'b0);
    send_beat(vpc_pkg::OpSuspend, 16'h0000, 16'h0000, 1'b0);   // suspend drops the pulse
    send_beat(vpc_pkg::OpPlay, 16'hFFFF, 16'hFFFF, 1'b0);      // rejected while suspended
    send_beat(vpc_pkg::OpResume, 16'h0000, 16'h0000, 1'b1);
    send_beat(vpc_pkg::OpPlay, 16'h5555, 16'hAAAA, 1'b0);
    send_beat(vpc_pkg::OpClose, 16'h0000, 16'h0000, 1'b0);
    send_beat(vpc_pkg::OpResume, 16'h0000, 16'h0000, 1'b0);    // resume while not suspended

    // Zero pulse length: the pulse ends within the play
    load_settings(7, 7, 0);
    send_beat(vpc_pkg::OpPlay, 16'hFFFF, 16'hFFFF, 1'b0);
    send_beat(vpc_pkg::OpTick, 16'h0000, 16'h0000, 1'b0);

    // Longest pulse length, idle code at zero
    load_settings(7, 0, 16'hFFFF);
    send_beat(vpc_pkg::OpPlay, 16'h1234, 16'h0000, 1'b0);
    send_beat(vpc_pkg::OpTick, 16'h0000, 16'h0000, 1'b0);
    send_beat(vpc_pkg::OpClose, 16'h0000, 16'h0000, 1'b0);

    // Random phases, each with its own register settings and idling pattern
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       max_on_pick = 1;
        1:       max_on_pick = $urandom_range(2, 6);
        2:       max_on_pick = 16'hFFFF;
        4:       max_on_pick = 0;
        default: max_on_pick = $urandom_range(1, 10);
      endcase
      load_settings((p == 0) ? 0 : (p == 1) ? 7 : $urandom_range(0, 7),
                    (p == 0) ? 7 : (p == 1) ? 0 : $urandom_range(0, 7),
                    max_on_pick);
      gap_odds   = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 4 : 12;
      stall_odds = (p % 3 == 2) ? 0 : (p % 3 == 0) ? 4 : 10;
      repeat (115) random_event(1'b0);
    end

    // Closing part, no idling: latch the fault one of three ways, then check
    // that everything stays blocked and that teardown is one-shot
    calm        = 1'b1;
    max_on_pick = $urandom_range(2, 5);
    load_settings($urandom_range(1, 7), $urandom_range(0, 7), max_on_pick);
    send_beat(vpc_pkg::OpResume, 16'h0000, 16'h0000, 1'b0);
    send_beat(vpc_pkg::OpClose, 16'h0000, 16'h0000, 1'b0);
    fault_path = $urandom_range(0, 2);
    case (fault_path)
      0: send_beat(vpc_pkg::OpPlay, 16'($urandom_range(1, 16'hFFFF)), 16'($urandom), 1'b1);
      1: begin
        // the final tick fails to switch the output off
        send_beat(vpc_pkg::OpPlay, 16'($urandom_range(1, 16'hFFFF)), 16'($urandom), 1'b0);
        run_ticks = max_on_pick - 1;
        repeat (run_ticks) send_beat(vpc_pkg::OpTick, 16'h0000, 16'h0000, 1'b0);
        send_beat(vpc_pkg::OpTick, 16'h0000, 16'h0000, 1'b1);
      end
      default: begin
        send_beat(vpc_pkg::OpPlay, 16'($urandom), 16'($urandom_range(1, 16'hFFFF)), 1'b0);
        send_beat(vpc_pkg::OpSuspend, 16'h0000, 16'h0000, 1'b1);
      end
    endcase
    send_beat(vpc_pkg::OpResume, 16'h0000, 16'h0000, 1'b0);    // stays blocked after fault
    send_beat(vpc_pkg::OpPlay, 16'hFFFF, 16'hFFFF, 1'b0);
    send_beat(vpc_pkg::OpTeardown, 16'h0000, 16'h0000, 1'b1);
    send_beat(vpc_pkg::OpTeardown, 16'h0000, 16'h0000, 1'b0);  // repeated teardown
    send_beat(vpc_pkg::OpResume, 16'h0000, 16'h0000, 1'b0);
    repeat (40) random_event(1'b1);

    // Let the last beats drain, then wait out the settle delay for strays
    wait_drained();
    repeat (SettleDelay) @(posedge clk_i);
    if (tracker.pending_outcomes.size() != 0)
      tracker.report($sformatf("%0d expected result beats never arrived",
                               tracker.pending_outcomes.size()));
    if (tracker.mismatches == 0) begin
      $display("PASS vibrator_pulse_controller_core");
    end else begin
      $display("FAIL vibrator_pulse_controller_core");
    end
    $finish;
  end

endmodule

### files.f
rtl/vpc_pkg.sv
rtl/vibrator_pulse_controller_core.sv
rtl/vpc_checker.sv
sim/testbench.sv
